// File: sv/i2cm_pkg.sv
// Shared types and constants for the I2C master bit engine.
package i2cm_pkg;

    // Sequencer phases; each non-idle phase except done is one half SCL period.
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START_A  = 4'd1,
        PH_START_B  = 4'd2,
        PH_STOP_A   = 4'd3,
        PH_STOP_B   = 4'd4,
        PH_WR_LOW   = 4'd5,
        PH_WR_HIGH  = 4'd6,
        PH_ACK_LOW  = 4'd7,
        PH_ACK_HIGH = 4'd8,
        PH_RD_LOW   = 4'd9,
        PH_RD_HIGH  = 4'd10,
        PH_MA_LOW   = 4'd11,
        PH_MA_HIGH  = 4'd12,
        PH_DONE     = 4'd13
    } t_phase;

    // Command codes carried on the func field.
    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_STOP  = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_READ  = 2'd3
    } t_func;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd500;
    localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;
    localparam logic [7:0]  MSB_MASK          = 8'h80;

    // Engine state apart from the half-period tick counter.
    typedef struct packed {
        t_phase      phase;
        logic [3:0]  bit_cnt;
        logic [7:0]  shift;
        logic        ack_choice;
        logic        scl;
        logic        sda;
        logic        drv;
        logic [7:0]  read_hold;
        logic        nack;
        logic        abort;
    } t_state;

    // Pin and status levels reported for one tick.
    typedef struct packed {
        logic        scl_out;
        logic        sda_out;
        logic        sda_drive;
        logic        busy;
        logic        done;
        logic [7:0]  read_byte;
        logic        nack_seen;
        logic        aborted;
    } t_result;

endpackage

// File: sv/i2cm_step.sv
// Next-state and result logic for one tick of the I2C master bit engine.
module i2cm_step #(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  i2cm_pkg::t_state                i_state,
    input  logic [TICK_COUNT_WIDTH-1:0]     i_tick,
    input  logic [15:0]                     i_half,
    input  logic                            i_cmd_valid,
    input  logic [1:0]                      i_func,
    input  logic [7:0]                      i_write_byte,
    input  logic                            i_send_nack,
    input  logic                            i_sda_in,
    output i2cm_pkg::t_state                o_state,
    output logic [TICK_COUNT_WIDTH-1:0]     o_tick,
    output i2cm_pkg::t_result               o_result
);

    localparam int CW = ((TICK_COUNT_WIDTH > 16) ? TICK_COUNT_WIDTH : 16) + 1;

    logic [CW-1:0] half_ext;
    logic [CW-1:0] limit;
    logic [CW-1:0] eff_half;
    logic          seg_more;

    assign half_ext = CW'(i_half);
    assign limit    = CW'(1) << TICK_COUNT_WIDTH;
    assign eff_half = (half_ext == '0) ? CW'(1) : ((half_ext > limit) ? limit : half_ext);
    assign seg_more = (CW'(i_tick) + CW'(1)) < eff_half;

    // Next state.
    always_comb begin
        i2cm_pkg::t_state n_st;
        logic [TICK_COUNT_WIDTH-1:0] n_tk;
        logic [7:0] sh;
        logic [3:0] bc;
        n_st = i_state;
        n_tk = i_tick;
        sh   = '0;
        bc   = '0;
        if (i_state.phase == i2cm_pkg::PH_DONE || i_state.phase == i2cm_pkg::PH_IDLE) begin
            n_st.phase = i2cm_pkg::PH_IDLE;
            if (i_cmd_valid) begin
                n_st.ack_choice = i_send_nack;
                n_st.abort      = 1'b0;
                n_st.bit_cnt    = '0;
                n_tk            = '0;
                case (i2cm_pkg::t_func'(i_func))
                    i2cm_pkg::FUNC_START: begin
                        n_st.phase = i2cm_pkg::PH_START_A;
                        {n_st.scl, n_st.sda, n_st.drv} = 3'b111;
                    end
                    i2cm_pkg::FUNC_STOP: begin
                        n_st.phase = i2cm_pkg::PH_STOP_A;
                        {n_st.scl, n_st.sda, n_st.drv} = 3'b001;
                    end
                    i2cm_pkg::FUNC_WRITE: begin
                        n_st.shift = i_write_byte;
                        n_st.nack  = 1'b0;
                        n_st.phase = i2cm_pkg::PH_WR_LOW;
                        n_st.scl   = 1'b0;
                        n_st.sda   = |(i_write_byte & i2cm_pkg::MSB_MASK);
                        n_st.drv   = 1'b1;
                    end
                    default: begin
                        n_st.shift = '0;
                        n_st.phase = i2cm_pkg::PH_RD_LOW;
                        n_st.scl   = 1'b0;
                        n_st.drv   = 1'b0;
                    end
                endcase
            end
        end else if (seg_more) begin
            n_tk = i_tick + TICK_COUNT_WIDTH'(1);
        end else begin
            n_tk = '0;
            case (i_state.phase)
                i2cm_pkg::PH_START_A: begin
                    n_st.phase = i2cm_pkg::PH_START_B;
                    {n_st.scl, n_st.sda, n_st.drv} = 3'b101;
                end
                i2cm_pkg::PH_START_B: begin
                    n_st.phase = i2cm_pkg::PH_DONE;
                    {n_st.scl, n_st.sda, n_st.drv} = 3'b001;
                end
                i2cm_pkg::PH_STOP_A: begin
                    n_st.phase = i2cm_pkg::PH_STOP_B;
                    {n_st.scl, n_st.sda, n_st.drv} = 3'b101;
                end
                i2cm_pkg::PH_STOP_B: begin
                    n_st.phase = i2cm_pkg::PH_DONE;
                    {n_st.scl, n_st.sda, n_st.drv} = 3'b111;
                end
                i2cm_pkg::PH_WR_LOW: begin
                    n_st.phase = i2cm_pkg::PH_WR_HIGH;
                    n_st.scl   = 1'b1;
                    n_st.drv   = 1'b1;
                end
                i2cm_pkg::PH_WR_HIGH: begin
                    sh           = {i_state.shift[6:0], 1'b0};
                    bc           = i_state.bit_cnt + 4'd1;
                    n_st.shift   = sh;
                    n_st.bit_cnt = bc;
                    if (bc >= i2cm_pkg::BITS_PER_BYTE) begin
                        n_st.phase = i2cm_pkg::PH_ACK_LOW;
                        n_st.scl   = 1'b0;
                        n_st.drv   = 1'b0;
                    end else begin
                        n_st.phase = i2cm_pkg::PH_WR_LOW;
                        n_st.scl   = 1'b0;
                        n_st.sda   = |(sh & i2cm_pkg::MSB_MASK);
                        n_st.drv   = 1'b1;
                    end
                end
                i2cm_pkg::PH_ACK_LOW: begin
                    n_st.phase = i2cm_pkg::PH_ACK_HIGH;
                    n_st.scl   = 1'b1;
                    n_st.drv   = 1'b0;
                end
                i2cm_pkg::PH_ACK_HIGH: begin
                    if (i_sda_in) begin
                        n_st.nack  = 1'b1;
                        n_st.abort = 1'b1;
                        n_st.phase = i2cm_pkg::PH_STOP_A;
                        {n_st.scl, n_st.sda, n_st.drv} = 3'b001;
                    end else begin
                        n_st.phase = i2cm_pkg::PH_DONE;
                        n_st.scl   = 1'b0;
                        n_st.drv   = 1'b1;
                    end
                end
                i2cm_pkg::PH_RD_LOW: begin
                    n_st.phase = i2cm_pkg::PH_RD_HIGH;
                    n_st.scl   = 1'b1;
                    n_st.drv   = 1'b0;
                end
                i2cm_pkg::PH_RD_HIGH: begin
                    sh           = {i_state.shift[6:0], i_sda_in};
                    bc           = i_state.bit_cnt + 4'd1;
                    n_st.shift   = sh;
                    n_st.bit_cnt = bc;
                    if (bc >= i2cm_pkg::BITS_PER_BYTE) begin
                        n_st.read_hold = sh;
                        n_st.phase     = i2cm_pkg::PH_MA_LOW;
                        n_st.scl       = 1'b0;
                        n_st.sda       = i_state.ack_choice;
                        n_st.drv       = 1'b1;
                    end else begin
                        n_st.phase = i2cm_pkg::PH_RD_LOW;
                        n_st.scl   = 1'b0;
                        n_st.drv   = 1'b0;
                    end
                end
                i2cm_pkg::PH_MA_LOW: begin
                    n_st.phase = i2cm_pkg::PH_MA_HIGH;
                    n_st.scl   = 1'b1;
                    n_st.sda   = i_state.ack_choice;
                    n_st.drv   = 1'b1;
                end
                i2cm_pkg::PH_MA_HIGH: begin
                    n_st.phase = i2cm_pkg::PH_DONE;
                    n_st.scl   = 1'b0;
                    n_st.sda   = i_state.ack_choice;
                    n_st.drv   = 1'b1;
                end
                default: begin
                    n_st.phase = i2cm_pkg::PH_IDLE;
                end
            endcase
        end
        o_state = n_st;
        o_tick  = n_tk;
    end

    // Result levels follow from the state after the tick.
    always_comb begin
        o_result.scl_out   = o_state.scl;
        o_result.sda_out   = o_state.drv ? o_state.sda : 1'b1;
        o_result.sda_drive = o_state.drv;
        o_result.busy      = (o_state.phase != i2cm_pkg::PH_IDLE) &&
                             (o_state.phase != i2cm_pkg::PH_DONE);
        o_result.done      = (o_state.phase == i2cm_pkg::PH_DONE);
        o_result.read_byte = o_state.read_hold;
        o_result.nack_seen = o_state.nack;
        o_result.aborted   = o_state.abort;
    end

endmodule

// File: sv/i2c_master_bit_engine_top.sv
// Top level of the I2C master bit engine: handshakes, state registers, result register.
//
// The engine is stepped once per input transaction; each transaction stands for one
// tick of the bus timebase and carries an optional command (start, stop, write byte,
// read byte), the write byte, the ACK/NACK choice for reads and the sampled SDA level.
// Every input transaction yields exactly one output transaction with the SCL, SDA and
// SDA-direction levels to drive plus busy, done, the last read byte and the NACK and
// abort flags. A command is only taken while idle or done; otherwise it is ignored.
// The half-period register is written through its own valid/ready channel, which is
// always ready; it should only be written while no transactions are in flight.
// The accepting edge loads the input register; when the step fires, the step result
// goes into the result register and output valid rises. Throughput is one transaction
// per cycle while the receiver does not stall. When the receiver stalls, the result
// register holds and the input register keeps accepting one more transaction before
// input ready drops; no transaction is lost.
// Synchronous active-low reset returns the engine to idle with SCL and SDA high and
// driven, clears counters and flags and loads a half period of 500 ticks.
module i2c_master_bit_engine_top #(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_half_period_ticks,
    // Input channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd_valid,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_write_byte,
    input  logic        i_send_nack,
    input  logic        i_sda_in,
    // Output channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_scl_out,
    output logic        o_sda_out,
    output logic        o_sda_drive,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_read_byte,
    output logic        o_nack_seen,
    output logic        o_aborted
);

    logic [15:0]                 r_half;
    i2cm_pkg::t_state            r_state;
    i2cm_pkg::t_state            n_state;
    logic [TICK_COUNT_WIDTH-1:0] r_tick;
    logic [TICK_COUNT_WIDTH-1:0] n_tick;

    // Input register.
    logic        r_in_valid;
    logic        r_cmd_valid;
    logic [1:0]  r_func;
    logic [7:0]  r_write_byte;
    logic        r_send_nack;
    logic        r_sda_in;

    // Result register.
    logic                r_out_valid;
    i2cm_pkg::t_result   r_result;
    i2cm_pkg::t_result   n_result;

    logic advance;

    // The step fires when the input register holds a transaction and the result
    // register is empty or being drained this cycle.
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= i2cm_pkg::HALF_PERIOD_RESET;
        end else if (i_cfg_valid) begin
            r_half <= i_cfg_half_period_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd_valid  <= i_cmd_valid;
            r_func       <= i_func;
            r_write_byte <= i_write_byte;
            r_send_nack  <= i_send_nack;
            r_sda_in     <= i_sda_in;
        end
    end

    i2cm_step #(
        .TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
    ) u_step (
        .i_state      (r_state),
        .i_tick       (r_tick),
        .i_half       (r_half),
        .i_cmd_valid  (r_cmd_valid),
        .i_func       (r_func),
        .i_write_byte (r_write_byte),
        .i_send_nack  (r_send_nack),
        .i_sda_in     (r_sda_in),
        .o_state      (n_state),
        .o_tick       (n_tick),
        .o_result     (n_result)
    );

    // Engine state moves only when a transaction passes through the step logic.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= i2cm_pkg::PH_IDLE;
            r_state.bit_cnt    <= '0;
            r_state.shift      <= '0;
            r_state.ack_choice <= 1'b0;
            r_state.scl        <= 1'b1;
            r_state.sda        <= 1'b1;
            r_state.drv        <= 1'b1;
            r_state.read_hold  <= '0;
            r_state.nack       <= 1'b0;
            r_state.abort      <= 1'b0;
            r_tick             <= '0;
        end else if (advance) begin
            r_state <= n_state;
            r_tick  <= n_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl_out   = r_result.scl_out;
    assign o_sda_out   = r_result.sda_out;
    assign o_sda_drive = r_result.sda_drive;
    assign o_busy_res  = r_result.busy;
    assign o_done_res  = r_result.done;
    assign o_read_byte = r_result.read_byte;
    assign o_nack_seen = r_result.nack_seen;
    assign o_aborted   = r_result.aborted;

endmodule

// File: sv/i2cm_checker.sv
// Port-level assertions for the I2C master bit engine and their bind.
module i2cm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_sda_out,
    input logic        o_sda_drive,
    input logic        o_busy_res,
    input logic        o_done_res,
    input logic [7:0]  o_read_byte
);

    // With no result pending the engine must take new transactions.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input not ready while output register is empty");

    // A finishing tick is never reported as busy.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done and busy reported together");

    // A released SDA line reads high.
    a_released_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_sda_drive |-> o_sda_out)
        else $error("sda_out low while SDA is released");

    // A stalled result keeps its read byte.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_byte))
        else $error("stalled output transaction changed");

endmodule

bind i2c_master_bit_engine_top i2cm_checker u_i2cm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_sda_out   (o_sda_out),
    .o_sda_drive (o_sda_drive),
    .o_busy_res  (o_busy_res),
    .o_done_res  (o_done_res),
    .o_read_byte (o_read_byte)
);
